[rtl/core/paged_gpio_controller_with_irq_macros.svh]
// Assertion macros for the paged GPIO controller.
`ifndef PAGED_GPIO_CONTROLLER_WITH_IRQ_MACROS_SVH
`define PAGED_GPIO_CONTROLLER_WITH_IRQ_MACROS_SVH
`ifndef SYNTHESIS
`define PGC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define PGC_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PGC_ASSERT(label, clk, rst_n, prop)
`define PGC_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/core/pgc_pkg.sv]
// Shared types and constants for the paged GPIO controller.
package pgc_pkg;
  localparam int unsigned Pages = 11;
  localparam int unsigned PageWidth = 16;
  localparam int unsigned PageAw = 4;

  typedef logic [PageWidth-1:0] pin_t;

  localparam logic [1:0] OpRead = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpSample = 2'd2;

  localparam logic [3:0] RegData = 4'd0;
  localparam logic [3:0] RegMask = 4'd1;
  localparam logic [3:0] RegDir = 4'd2;
  localparam logic [3:0] RegSense = 4'd3;
  localparam logic [3:0] RegBoth = 4'd4;
  localparam logic [3:0] RegPol = 4'd5;
  localparam logic [3:0] RegEnable = 4'd6;
  localparam logic [3:0] RegRaw = 4'd7;
  localparam logic [3:0] RegMasked = 4'd8;
  localparam logic [3:0] RegClear = 4'd9;

  typedef struct packed {
    pin_t latch;
    pin_t mask;
    pin_t dir;
    pin_t sense;
    pin_t both;
    pin_t pol;
    pin_t en;
    pin_t raw;
    pin_t last;
  } page_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  sel;
    pin_t        wdata;
    pin_t        pins;
  } cmd_t;

  typedef struct packed {
    page_t      page;
    pin_t       rdata;
  } upd_t;
endpackage

[rtl/core/paged_gpio_controller_with_irq.sv]
// Paged GPIO controller top level: page memory sequencer and IRQ summary.
// Result path: page memory read register, then the output registers and out_valid_o.
// Input: no new item is taken during page memory write-back or while a result is held stalled.
// Reset: all page registers read as zero; interrupt pending bits cleared.
`include "paged_gpio_controller_with_irq_macros.svh"
module paged_gpio_controller_with_irq import pgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  page_i,
  input  logic [3:0]  reg_sel_i,
  input  logic [15:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        access_error_o,
  output logic [15:0] drive_value_o,
  output logic [15:0] drive_enable_o,
  output logic        irq_out_o
);
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;
  cmd_t cmd_q;
  logic [PageAw-1:0] page_q;
  logic err_q;
  logic [Pages-1:0] pend_q;
  logic ovld_q;
  pin_t rd_q, dv_q, de_q;
  logic oerr_q;
  page_t cur;
  upd_t upd;
  logic accept, in_err, wb;
  logic [Pages-1:0] pend_d;

  assign in_err = ({1'b0, page_i} >= (PageAw+1)'(Pages));
  assign in_stall_o = (state_q != StIdle) || (ovld_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;
  assign wb = (state_q == StExec) && !err_q;

  pgc_page_ram u_ram (
    .clk_i, .rst_ni,
    .re_i(accept), .raddr_i(page_i), .rdata_o(cur),
    .we_i(wb), .waddr_i(page_q), .wdata_i(upd.page)
  );

  pgc_update u_upd (.cmd_i(cmd_q), .cur_i(cur), .upd_o(upd));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StExec;
      StExec:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
    pend_d = pend_q;
    if (wb) begin
      pend_d[page_q[$clog2(Pages > 1 ? Pages : 2)-1:0]] = |(upd.page.raw & upd.page.en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= '{op: op_i, sel: reg_sel_i, wdata: write_data_i, pins: pin_levels_i};
      page_q <= page_i;
    end
    if (state_q == StExec) begin
      rd_q <= err_q ? '0 : upd.rdata;
      dv_q <= err_q ? '0 : upd.page.latch;
      de_q <= err_q ? '0 : upd.page.dir;
      oerr_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      err_q <= 1'b0;
      pend_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      if (accept) begin
        err_q <= in_err;
      end
      if (state_q == StExec) begin
        ovld_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign read_data_o = rd_q;
  assign access_error_o = oerr_q;
  assign drive_value_o = dv_q;
  assign drive_enable_o = de_q;
  assign irq_out_o = |pend_q;

  `PGC_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `PGC_ASSERT(a_exec_follows, clk_i, rst_ni, accept |=> (state_q == StExec))
  `PGC_ASSERT(a_no_wb_err, clk_i, rst_ni, (state_q == StExec) && err_q |-> !wb)
  `PGC_ASSERT(a_out_after, clk_i, rst_ni, (state_q == StExec) |=> out_valid_o)
endmodule

[rtl/core/pgc_page_ram.sv]
// Page register memory with registered read and per-page valid bits.
module pgc_page_ram import pgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [PageAw-1:0] raddr_i,
  output page_t             rdata_o,
  input  logic              we_i,
  input  logic [PageAw-1:0] waddr_i,
  input  page_t             wdata_i
);
  page_t mem_q [Pages];
  page_t rd_q;
  logic [Pages-1:0] vld_q;
  logic rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;
endmodule

[rtl/core/pgc_update.sv]
// Read-modify logic for one page: register access and pin sampling.
module pgc_update import pgc_pkg::*; (
  input  cmd_t  cmd_i,
  input  page_t cur_i,
  output upd_t  upd_o
);
  page_t n;
  pin_t rise, fall, single, edg, lvl, rd;

  always_comb begin
    n = cur_i;
    rd = '0;
    rise = cmd_i.pins & ~cur_i.last;
    fall = ~cmd_i.pins & cur_i.last;
    single = (rise & cur_i.pol) | (fall & ~cur_i.pol);
    edg = ((rise | fall) & cur_i.both) | (single & ~cur_i.both);
    case (cmd_i.op)
      OpRead: begin
        case (cmd_i.sel)
          RegData:   rd = ((cur_i.dir & cur_i.latch) | (~cur_i.dir & cur_i.last)) & cur_i.mask;
          RegMask:   rd = cur_i.mask;
          RegDir:    rd = cur_i.dir;
          RegSense:  rd = cur_i.sense;
          RegBoth:   rd = cur_i.both;
          RegPol:    rd = cur_i.pol;
          RegEnable: rd = cur_i.en;
          RegRaw:    rd = cur_i.raw;
          RegMasked: rd = cur_i.raw & cur_i.en;
          default:   rd = '0;
        endcase
      end
      OpWrite: begin
        case (cmd_i.sel)
          RegData:   n.latch = (cur_i.latch & ~cur_i.mask) | (cmd_i.wdata & cur_i.mask);
          RegMask:   n.mask = cmd_i.wdata;
          RegDir:    n.dir = cmd_i.wdata;
          RegSense: begin
            n.sense = cmd_i.wdata;
            n.raw = cur_i.raw & ~(cur_i.sense & ~cmd_i.wdata);
          end
          RegBoth:   n.both = cmd_i.wdata;
          RegPol:    n.pol = cmd_i.wdata;
          RegEnable: n.en = cmd_i.wdata;
          RegClear:  n.raw = cur_i.raw & ~(cmd_i.wdata & ~cur_i.sense);
          default:   n = cur_i;
        endcase
      end
      OpSample: begin
        n.last = cmd_i.pins;
        n.raw = cur_i.raw | (edg & ~cur_i.sense);
      end
      default: n = cur_i;
    endcase
    lvl = ~(n.last ^ n.pol);
    if ((cmd_i.op == OpSample) || ((cmd_i.op == OpWrite) &&
        ((cmd_i.sel == RegSense) || (cmd_i.sel == RegPol)))) begin
      n.raw = (n.raw & ~n.sense) | (lvl & n.sense);
    end
    upd_o.page = n;
    upd_o.rdata = rd;
  end
endmodule

[verif/tb.sv]
// Self-checking testbench for the paged GPIO controller: directed and random transfers.
module tb;
  import pgc_pkg::*;

  localparam logic [1:0] OpIdle = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [3:0]  page_i = '0;
  logic [3:0]  reg_sel_i = '0;
  logic [15:0] write_data_i = '0;
  logic [15:0] pin_levels_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] read_data_o;
  logic        access_error_o;
  logic [15:0] drive_value_o;
  logic [15:0] drive_enable_o;
  logic        irq_out_o;

  paged_gpio_controller_with_irq i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [15:0] rdata;
    logic        err;
    logic [15:0] dval;
    logic [15:0] den;
    logic        irq;
  } gpio_resp_t;

  pin_t m_latch [16];
  pin_t m_mask  [16];
  pin_t m_dir   [16];
  pin_t m_sense [16];
  pin_t m_both  [16];
  pin_t m_pol   [16];
  pin_t m_en    [16];
  pin_t m_raw   [16];
  pin_t m_last  [16];
  logic [15:0] m_pending;

  gpio_resp_t resp_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 0;

  function automatic void model_reset();
    for (int p = 0; p < 16; p++) begin
      m_latch[p] = '0; m_mask[p] = '0; m_dir[p] = '0; m_sense[p] = '0;
      m_both[p] = '0; m_pol[p] = '0; m_en[p] = '0; m_raw[p] = '0; m_last[p] = '0;
    end
    m_pending = '0;
  endfunction

  function automatic void refresh_level(int p);
    pin_t lv;
    lv = (m_last[p] & m_pol[p]) | (~m_last[p] & ~m_pol[p]);
    m_raw[p] = (m_raw[p] & ~m_sense[p]) | (lv & m_sense[p]);
  endfunction

  function automatic gpio_resp_t predict_gpio(logic [1:0] op, logic [3:0] pg,
                                              logic [3:0] sel, pin_t wd, pin_t pins);
    gpio_resp_t r;
    pin_t rise, fall, single, edg;
    r = '0;
    r.err = (pg >= Pages);
    if (!r.err) begin
      if (op == OpRead) begin
        case (sel)
          RegData:   r.rdata = ((m_dir[pg] & m_latch[pg]) | (~m_dir[pg] & m_last[pg]))
                               & m_mask[pg];
          RegMask:   r.rdata = m_mask[pg];
          RegDir:    r.rdata = m_dir[pg];
          RegSense:  r.rdata = m_sense[pg];
          RegBoth:   r.rdata = m_both[pg];
          RegPol:    r.rdata = m_pol[pg];
          RegEnable: r.rdata = m_en[pg];
          RegRaw:    r.rdata = m_raw[pg];
          RegMasked: r.rdata = m_raw[pg] & m_en[pg];
          default:   r.rdata = '0;
        endcase
      end else if (op == OpWrite) begin
        case (sel)
          RegData:   m_latch[pg] = (m_latch[pg] & ~m_mask[pg]) | (wd & m_mask[pg]);
          RegMask:   m_mask[pg] = wd;
          RegDir:    m_dir[pg] = wd;
          RegSense: begin
            m_raw[pg] &= ~(m_sense[pg] & ~wd);
            m_sense[pg] = wd;
            refresh_level(pg);
          end
          RegBoth:   m_both[pg] = wd;
          RegPol: begin
            m_pol[pg] = wd;
            refresh_level(pg);
          end
          RegEnable: m_en[pg] = wd;
          RegClear:  m_raw[pg] &= ~(wd & ~m_sense[pg]);
          default: ;
        endcase
      end else if (op == OpSample) begin
        rise = pins & ~m_last[pg];
        fall = ~pins & m_last[pg];
        single = (rise & m_pol[pg]) | (fall & ~m_pol[pg]);
        edg = ((rise | fall) & m_both[pg]) | (single & ~m_both[pg]);
        m_last[pg] = pins;
        m_raw[pg] |= edg & ~m_sense[pg];
        refresh_level(pg);
      end
      m_pending[pg] = |(m_raw[pg] & m_en[pg]);
      r.dval = m_latch[pg];
      r.den = m_dir[pg];
    end
    r.irq = |m_pending;
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [3:0] pg, logic [3:0] sel,
                           pin_t wd, pin_t pins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; page_i <= pg; reg_sel_i <= sel;
    write_data_i <= wd; pin_levels_i <= pins;
    resp_q.push_back(predict_gpio(op, pg, sel, wd, pins));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    gpio_resp_t exp_r, act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act = '{read_data_o, access_error_o, drive_value_o, drive_enable_o, irq_out_o};
      if (resp_q.size() == 0) begin
        $display("%0t unexpected transfer: actual %h", $time, act);
        errors++;
      end else begin
        exp_r = resp_q.pop_front();
        if (act !== exp_r) begin
          $display("%0t mismatch: expected %h actual %h", $time, exp_r, act);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    for (int s = 0; s < 16; s++) send_item(OpRead, 4'd0, s[3:0], '0, '0);
    send_item(OpWrite, 4'd1, RegMask, 16'hffff, '0);
    send_item(OpWrite, 4'd1, RegDir, 16'h00ff, '0);
    send_item(OpWrite, 4'd1, RegData, 16'hffff, '0);
    send_item(OpWrite, 4'd1, RegEnable, 16'hffff, '0);
    send_item(OpWrite, 4'd1, RegBoth, 16'h0f0f, '0);
    send_item(OpSample, 4'd1, RegData, '0, 16'hffff);
    send_item(OpRead, 4'd1, RegRaw, '0, '0);
    send_item(OpWrite, 4'd1, RegSense, 16'hf000, '0);
    send_item(OpWrite, 4'd1, RegPol, 16'h8000, '0);
    send_item(OpWrite, 4'd1, RegClear, 16'hffff, '0);
    send_item(OpRead, 4'd1, RegMasked, '0, '0);
    send_item(OpWrite, 4'd15, RegData, 16'hffff, '0);
    send_item(OpIdle, 4'd10, RegData, '0, 16'hffff);
  endtask

  task automatic rand_item();
    logic [1:0] op;
    logic [3:0] pg, sel;
    op = $urandom_range(99) < 45 ? OpSample : 2'($urandom_range(3));
    pg = $urandom_range(99) < 90 ? 4'($urandom_range(Pages - 1)) : 4'($urandom_range(15));
    sel = $urandom_range(99) < 92 ? 4'($urandom_range(9)) : 4'($urandom_range(15));
    send_item(op, pg, sel, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) rand_item();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (60) @(posedge clk_i);
        hold_recv = 0;
      end
      test_random(40);
    join
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 14; recv_idle_pct = 59;
    test_random(320);
    send_idle_pct = 59; recv_idle_pct = 14;
    test_random(320);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(320);
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
